// ----- hdl/olb_pkg.sv -----
// Shared constants, types and the activation table for the 2-2-2 backprop trainer.
// No dependencies.
package olb_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int WORD_BITS     = 16;
  localparam int TABLE_ENTRIES = 256;
  localparam int TIDX_W        = $clog2(TABLE_ENTRIES);
  localparam int NPARAM        = 12;
  localparam int PIDX_W        = 4;
  localparam int ACT_W         = 14;
  localparam int LR_W          = 12;

  localparam logic [1:0] FUNC_TRAIN = 2'd0;
  localparam logic [1:0] FUNC_INFER = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;

  localparam logic       REG_LR     = 1'b0;
  localparam logic [LR_W-1:0] LR_RESET = 12'd819;

  localparam logic signed [31:0] ONE32   = 32'sd1 <<< FRAC_BITS;
  localparam logic [31:0]        MAG_MAX = 32'd16 << FRAC_BITS;

  typedef logic [ACT_W-2:0] act_tab_t [TABLE_ENTRIES];

  // restoring long division, elaboration time only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic act_tab_t build_act_table();
    act_tab_t t;
    longint unsigned v, sum, term, m, q30;
    q30 = 64'd1 << 30;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      v = ((64'(k) << 33) >> TIDX_W) >> 4;
      sum = q30;
      term = q30;
      for (int n = 1; n <= 14; n++) begin
        term = udiv64((term * v) >> 30, 64'(n));
        sum = sum + term;
      end
      m = udiv64(64'd1 << 60, sum);
      for (int s = 0; s < 4; s++) begin
        m = (m * m + (64'd1 << 29)) >> 30;
      end
      t[k] = (ACT_W-1)'(udiv64(((q30 - m) << FRAC_BITS) + ((q30 + m) >> 1), q30 + m));
    end
    return t;
  endfunction

  localparam act_tab_t ACT_TABLE = build_act_table();

  // bipolar sigmoid through the tanh table, odd symmetry
  function automatic logic signed [ACT_W-1:0] act_fn(input logic signed [31:0] a);
    logic [31:0] mag;
    logic [31:0] idx;
    logic [ACT_W-2:0] v;
    mag = a[31] ? 32'(-a) : 32'(a);
    if (mag > MAG_MAX) mag = MAG_MAX;
    idx = 32'((mag * 32'(TABLE_ENTRIES) + (32'd1 << (FRAC_BITS + 2))) >> (FRAC_BITS + 3));
    if (idx > 32'(TABLE_ENTRIES - 1)) idx = 32'(TABLE_ENTRIES - 1);
    v = ACT_TABLE[idx[TIDX_W-1:0]];
    return a[31] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

// ----- hdl/online_backprop_2x2x2_bipolar.sv -----
// Infer ends at the output layer; train goes on to update; load and unused func skip both.
// One request at a time; the next is taken once the result sits in the output register.
// Train time is set by the single shared 32x32 multiplier (issue plus write-back per product)
// and the 12-word parameter memory, read and rewritten one word per cycle.
// Synchronous reset: parameters zero, learning rate 819, no result pending.
// Depends on olb_pkg.
module online_backprop_2x2x2_bipolar (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               func,
  input  logic                     x_first,
  input  logic                     x_second,
  input  logic                     target_first,
  input  logic                     target_second,
  input  logic [3:0]               param_index,
  input  logic signed [15:0]       param_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [13:0]       out_first,
  output logic signed [13:0]       out_second,
  output logic signed [13:0]       err_first,
  output logic signed [13:0]       err_second,
  output logic                     clipped
);
  import olb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ACTH, S_MUL, S_WB, S_ACTO, S_UPD, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    R_T1, R_T2, R_T3, R_T4, R_G1, R_G2, R_H1, R_H2,
    R_S1, R_S2, R_Q4, R_Q5, R_Q6, R_Q7, R_Q10, R_Q11
  } dst_t;

  localparam logic signed [32:0] WMAX = (33'sd1 <<< (WORD_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] WMIN = -(33'sd1 <<< (WORD_BITS - 1));

  state_t state;
  logic [LR_W-1:0] lr;
  logic [1:0] fn;
  logic x1, x2, t1, t2;
  logic [3:0] cnt;
  logic [4:0] step;
  logic signed [WORD_BITS-1:0] cache [NPARAM];
  logic signed [31:0] scr [16];
  logic signed [ACT_W-1:0] y1, y2, z1, z2, d1, d2;
  logic clip;
  logic signed [63:0] prod;
  logic half_q;
  dst_t dst_q;

  logic signed [WORD_BITS-1:0] mem [NPARAM];
  logic signed [WORD_BITS-1:0] rdata;
  logic mem_we;
  logic [3:0] waddr, raddr;
  logic signed [WORD_BITS-1:0] wdata;
  logic [NPARAM-1:0] wr_ok;
  logic rd_ok;

  logic signed [31:0] mul_a, mul_b;
  logic mul_half;
  dst_t mul_dst;
  logic signed [63:0] rsum, rnd_val;
  logic signed [31:0] upd_delta;
  logic upd_sub;
  logic signed [32:0] upd_n;
  logic signed [WORD_BITS-1:0] upd_sat;
  logic upd_clip;
  logic in_acc, cfg_wr;
  logic signed [31:0] ah1, ah2, ao1, ao2;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LR);
  assign prdata = (paddr[2] == REG_LR) ? {20'b0, lr} : 32'b0;
  assign in_stall = (state != S_IDLE);
  assign in_acc = in_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) lr <= LR_RESET;
    else if (cfg_wr) lr <= pwdata[LR_W-1:0];
  end

  // microcode for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_half = 1'b0;
    mul_dst = R_T1;
    unique case (step)
      5'd0:  begin mul_a = 32'(cache[4]); mul_b = 32'(y1); mul_dst = R_T1; end
      5'd1:  begin mul_a = 32'(cache[5]); mul_b = 32'(y2); mul_dst = R_T2; end
      5'd2:  begin mul_a = 32'(cache[6]); mul_b = 32'(y1); mul_dst = R_T3; end
      5'd3:  begin mul_a = 32'(cache[7]); mul_b = 32'(y2); mul_dst = R_T4; end
      5'd4:  begin mul_a = 32'(z1); mul_b = 32'(z1); mul_dst = R_T1; end
      5'd5:  begin mul_a = 32'(z2); mul_b = 32'(z2); mul_dst = R_T2; end
      5'd6:  begin
        mul_a = 32'(d1); mul_b = ONE32 - scr[R_T1]; mul_half = 1'b1; mul_dst = R_G1;
      end
      5'd7:  begin
        mul_a = 32'(d2); mul_b = ONE32 - scr[R_T2]; mul_half = 1'b1; mul_dst = R_G2;
      end
      5'd8:  begin mul_a = 32'(y1); mul_b = 32'(y1); mul_dst = R_T1; end
      5'd9:  begin mul_a = 32'(y2); mul_b = 32'(y2); mul_dst = R_T2; end
      5'd10: begin mul_a = scr[R_G1]; mul_b = 32'(cache[4]); mul_dst = R_T3; end
      5'd11: begin mul_a = scr[R_G2]; mul_b = 32'(cache[6]); mul_dst = R_T4; end
      5'd12: begin
        mul_a = scr[R_T3] + scr[R_T4]; mul_b = ONE32 - scr[R_T1];
        mul_half = 1'b1; mul_dst = R_H1;
      end
      5'd13: begin mul_a = scr[R_G1]; mul_b = 32'(cache[5]); mul_dst = R_T3; end
      5'd14: begin mul_a = scr[R_G2]; mul_b = 32'(cache[7]); mul_dst = R_T4; end
      5'd15: begin
        mul_a = scr[R_T3] + scr[R_T4]; mul_b = ONE32 - scr[R_T2];
        mul_half = 1'b1; mul_dst = R_H2;
      end
      5'd16: begin mul_a = $signed({20'b0, lr}); mul_b = scr[R_H1]; mul_dst = R_S1; end
      5'd17: begin mul_a = $signed({20'b0, lr}); mul_b = scr[R_H2]; mul_dst = R_S2; end
      5'd18: begin mul_a = scr[R_G1]; mul_b = 32'(y1); mul_dst = R_T1; end
      5'd19: begin mul_a = $signed({20'b0, lr}); mul_b = scr[R_T1]; mul_dst = R_Q4; end
      5'd20: begin mul_a = scr[R_G1]; mul_b = 32'(y2); mul_dst = R_T1; end
      5'd21: begin mul_a = $signed({20'b0, lr}); mul_b = scr[R_T1]; mul_dst = R_Q5; end
      5'd22: begin mul_a = scr[R_G2]; mul_b = 32'(y1); mul_dst = R_T1; end
      5'd23: begin mul_a = $signed({20'b0, lr}); mul_b = scr[R_T1]; mul_dst = R_Q6; end
      5'd24: begin mul_a = scr[R_G2]; mul_b = 32'(y2); mul_dst = R_T1; end
      5'd25: begin mul_a = $signed({20'b0, lr}); mul_b = scr[R_T1]; mul_dst = R_Q7; end
      5'd26: begin mul_a = $signed({20'b0, lr}); mul_b = scr[R_G1]; mul_dst = R_Q10; end
      5'd27: begin mul_a = $signed({20'b0, lr}); mul_b = scr[R_G2]; mul_dst = R_Q11; end
      default: ;
    endcase
  end

  always_comb begin
    rsum = prod + (half_q ? (64'sd1 <<< FRAC_BITS) : (64'sd1 <<< (FRAC_BITS - 1)));
    rnd_val = half_q ? (rsum >>> (FRAC_BITS + 1)) : (rsum >>> FRAC_BITS);
  end

  assign ah1 = (x1 ? 32'(cache[0]) : 32'sd0) + (x2 ? 32'(cache[1]) : 32'sd0) - 32'(cache[8]);
  assign ah2 = (x1 ? 32'(cache[2]) : 32'sd0) + (x2 ? 32'(cache[3]) : 32'sd0) - 32'(cache[9]);
  assign ao1 = scr[R_T1] + scr[R_T2] - 32'(cache[10]);
  assign ao2 = scr[R_T3] + scr[R_T4] - 32'(cache[11]);

  always_comb begin
    upd_delta = '0;
    upd_sub = 1'b1;
    unique case (cnt)
      4'd0:  upd_delta = x1 ? scr[R_S1] : 32'sd0;
      4'd1:  upd_delta = x2 ? scr[R_S1] : 32'sd0;
      4'd2:  upd_delta = x1 ? scr[R_S2] : 32'sd0;
      4'd3:  upd_delta = x2 ? scr[R_S2] : 32'sd0;
      4'd4:  upd_delta = scr[R_Q4];
      4'd5:  upd_delta = scr[R_Q5];
      4'd6:  upd_delta = scr[R_Q6];
      4'd7:  upd_delta = scr[R_Q7];
      4'd8:  begin upd_delta = scr[R_S1]; upd_sub = 1'b0; end
      4'd9:  begin upd_delta = scr[R_S2]; upd_sub = 1'b0; end
      4'd10: begin upd_delta = scr[R_Q10]; upd_sub = 1'b0; end
      4'd11: begin upd_delta = scr[R_Q11]; upd_sub = 1'b0; end
      default: ;
    endcase
    upd_n = upd_sub ? (33'(cache[cnt]) - 33'(upd_delta)) : (33'(cache[cnt]) + 33'(upd_delta));
    upd_clip = 1'b0;
    if (upd_n > WMAX) begin
      upd_sat = WORD_BITS'(WMAX);
      upd_clip = 1'b1;
    end else if (upd_n < WMIN) begin
      upd_sat = WORD_BITS'(WMIN);
      upd_clip = 1'b1;
    end else begin
      upd_sat = upd_n[WORD_BITS-1:0];
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr = cnt;
    wdata = upd_sat;
    if (in_acc && func == FUNC_LOAD && param_index < 4'(NPARAM)) begin
      mem_we = 1'b1;
      waddr = param_index;
      wdata = param_value;
    end else if (state == S_UPD) begin
      mem_we = 1'b1;
    end
    raddr = (cnt < 4'(NPARAM)) ? cnt : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
    rd_ok <= wr_ok[raddr];
  end

  // entries read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) wr_ok <= '0;
    else if (mem_we) wr_ok[waddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
      step <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fn <= func;
            x1 <= x_first;
            x2 <= x_second;
            t1 <= target_first;
            t2 <= target_second;
            z1 <= '0;
            z2 <= '0;
            d1 <= '0;
            d2 <= '0;
            clip <= 1'b0;
            cnt <= '0;
            step <= '0;
            if (func == FUNC_TRAIN || func == FUNC_INFER) state <= S_LOAD;
            else state <= S_DONE;
          end
        end
        S_LOAD: begin
          if (cnt != 4'd0) cache[cnt - 4'd1] <= rd_ok ? rdata : '0;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(NPARAM)) state <= S_ACTH;
        end
        S_ACTH: begin
          y1 <= act_fn(ah1);
          y2 <= act_fn(ah2);
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= mul_a * mul_b;
          half_q <= mul_half;
          dst_q <= mul_dst;
          state <= S_WB;
        end
        S_WB: begin
          scr[dst_q] <= rnd_val[31:0];
          step <= step + 5'd1;
          cnt <= '0;
          if (step == 5'd3) state <= S_ACTO;
          else if (step == 5'd27) state <= S_UPD;
          else state <= S_MUL;
        end
        S_ACTO: begin
          z1 <= act_fn(ao1);
          z2 <= act_fn(ao2);
          d1 <= act_fn(ao1) - (t1 ? ACT_W'(ONE32) : '0);
          d2 <= act_fn(ao2) - (t2 ? ACT_W'(ONE32) : '0);
          state <= (fn == FUNC_TRAIN) ? S_MUL : S_DONE;
        end
        S_UPD: begin
          clip <= clip | upd_clip;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(NPARAM - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_first <= z1;
            out_second <= z2;
            err_first <= d1;
            err_second <= d2;
            clipped <= clip;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
